>>> design/lbcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbcs_pkg: shared definitions for the letter bucket chained stacks
// Operation and status codes, command and status structs between the
// controller and the datapath, and the letter to bucket mapping.
// ----------------------------------------------------------------------------
package lbcs_pkg;

    localparam int POOL_ENTRIES_DEFAULT = 256;
    localparam int NUM_BUCKETS          = 26;
    localparam int BUCKET_W             = $clog2(NUM_BUCKETS);
    localparam int OUT_LEN_W            = 9;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NOT_LETTER = 2'd1,
        STATUS_EMPTY      = 2'd2,
        STATUS_FULL       = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic read_entry;
        logic commit;
    } lbcs_cmd_t;

    typedef struct packed {
        logic need_pop;
        logic out_free;
    } lbcs_stat_t;

    typedef struct packed {
        logic                valid;
        logic [BUCKET_W-1:0] idx;
    } letter_t;

    function automatic letter_t letter_bucket(input logic [7:0] c);
        letter_t     res;
        logic [7:0]  diff;
        res  = '0;
        diff = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            diff      = c - CHAR_UPPER_A;
            res.valid = 1'b1;
            res.idx   = diff[BUCKET_W-1:0];
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            diff      = c - CHAR_LOWER_A;
            res.valid = 1'b1;
            res.idx   = diff[BUCKET_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> design/lbcs_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbcs_cmd_if: request channel
// Carries one operation item: the operation code and the character byte.
// ----------------------------------------------------------------------------
interface lbcs_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] character;

    modport source (output valid, output func, output character, input ready);
    modport sink (input valid, input func, input character, output ready);
endinterface
`default_nettype wire

>>> design/lbcs_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbcs_rsp_if: result channel
// Carries one result item: status, bucket, removed character and length.
// ----------------------------------------------------------------------------
interface lbcs_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [4:0] bucket;
    logic [7:0] removed_char;
    logic [8:0] bucket_length;

    modport source (output valid, output status, output bucket, output removed_char,
                    output bucket_length, input ready);
    modport sink (input valid, input status, input bucket, input removed_char,
                  input bucket_length, output ready);
endinterface
`default_nettype wire

>>> design/lbcs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbcs_ram: generic single-port RAM
// One address per cycle, write, registered read or both.
// ----------------------------------------------------------------------------
module lbcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> design/lbcs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbcs_ctrl: operation sequencer
// Accepts an item, waits for the head pointer read, adds an entry read for a
// pop, and commits the result once the output register is free.
// ----------------------------------------------------------------------------
module lbcs_ctrl
    import lbcs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire lbcs_stat_t stat,
    output lbcs_cmd_t       ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_POP
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && ready_reg)
                    begin
                        state_reg <= S_HEAD;
                        ready_reg <= 1'b0;
                    end
                end
                S_HEAD:
                begin
                    if (stat.need_pop)
                    begin
                        state_reg <= S_POP;
                    end
                    else if (stat.out_free)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                S_POP:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        ctl.load       = (state_reg == S_IDLE) && ready_reg && in_valid;
        ctl.read_entry = (state_reg == S_HEAD) && stat.need_pop;
        ctl.commit     = ((state_reg == S_HEAD) && !stat.need_pop && stat.out_free)
                      || ((state_reg == S_POP) && stat.out_free);
    end

    assign in_ready = ready_reg;

endmodule
`default_nettype wire

>>> design/lbcs_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbcs_datapath: bucket chains, entry pool and result register
// Holds the head pointer and entry memories, the bucket lengths, the free
// list and the allocation counter, and forms each result item.
// ----------------------------------------------------------------------------
module lbcs_datapath
    import lbcs_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lbcs_cmd_t  ctl,
    output lbcs_stat_t      stat,
    input  wire logic [1:0] item_func,
    input  wire logic [7:0] item_character,
    lbcs_rsp_if.source      rsp
);

    localparam int PW = $clog2(POOL_ENTRIES);
    localparam int LW = PW + 1;
    localparam int EW = PW + 8;
    localparam logic [LW-1:0] POOL_LIMIT = LW'(POOL_ENTRIES);

    logic [1:0]          func_reg;
    logic [7:0]          char_reg;
    logic [BUCKET_W-1:0] bucket_reg;
    logic                letter_reg;
    logic [PW-1:0]       free_head_reg;
    logic [LW-1:0]       total_reg;
    logic [LW-1:0]       fresh_reg;
    logic [LW-1:0]       len_reg [NUM_BUCKETS];

    logic                out_valid_reg;
    status_t             status_reg;
    logic [BUCKET_W-1:0] bucket_out_reg;
    logic [7:0]          removed_reg;
    logic [OUT_LEN_W-1:0] length_out_reg;

    letter_t             item_letter;
    logic [PW-1:0]       head_rdata;
    logic [EW-1:0]       entry_rdata;
    logic [PW-1:0]       entry_next;
    logic [7:0]          entry_char;
    logic [LW-1:0]       len_cur;
    logic                is_insert;
    logic                is_delete;
    logic                free_valid;
    logic                fresh_avail;
    logic                ins_got;
    logic                pop;
    logic [PW-1:0]       alloc_idx;

    status_t             status_new;
    logic [7:0]          removed_new;
    logic [LW-1:0]       len_new;
    logic [OUT_LEN_W-1:0] len_out;

    logic                head_we;
    logic                head_re;
    logic [BUCKET_W-1:0] head_addr;
    logic [PW-1:0]       head_wdata;
    logic                entry_we;
    logic                entry_re;
    logic [PW-1:0]       entry_addr;
    logic [EW-1:0]       entry_wdata;

    assign item_letter = letter_bucket(item_character);
    assign entry_next  = entry_rdata[EW-1:8];
    assign entry_char  = entry_rdata[7:0];
    assign len_cur     = len_reg[bucket_reg];
    assign is_insert   = letter_reg && (func_reg == FUNC_INSERT);
    assign is_delete   = letter_reg && (func_reg == FUNC_DELETE);
    assign free_valid  = total_reg < fresh_reg;
    assign fresh_avail = fresh_reg < POOL_LIMIT;
    assign ins_got     = is_insert && (free_valid || fresh_avail);
    assign pop         = is_delete && (len_cur != '0);
    assign alloc_idx   = free_valid ? free_head_reg : fresh_reg[PW-1:0];

    always_comb
    begin
        status_new  = STATUS_OK;
        removed_new = '0;
        len_new     = '0;
        if (!letter_reg)
        begin
            status_new = STATUS_NOT_LETTER;
        end
        else if (func_reg == FUNC_INSERT)
        begin
            if (ins_got)
            begin
                len_new = len_cur + LW'(1);
            end
            else
            begin
                status_new = STATUS_FULL;
                len_new    = len_cur;
            end
        end
        else if (func_reg == FUNC_DELETE)
        begin
            if (pop)
            begin
                removed_new = entry_char;
                len_new     = len_cur - LW'(1);
            end
            else
            begin
                status_new = STATUS_EMPTY;
            end
        end
        else
        begin
            len_new = len_cur;
        end
    end

    generate
        if (LW >= OUT_LEN_W)
        begin : g_len_trunc
            assign len_out = len_new[OUT_LEN_W-1:0];
        end
        else
        begin : g_len_ext
            assign len_out = {{(OUT_LEN_W-LW){1'b0}}, len_new};
        end
    endgenerate

    always_comb
    begin
        head_re    = ctl.load;
        head_we    = ctl.commit && (ins_got || pop);
        head_addr  = ctl.load ? item_letter.idx : bucket_reg;
        head_wdata = ins_got ? alloc_idx : entry_next;

        entry_re    = ctl.load || ctl.read_entry;
        entry_we    = ctl.commit && (ins_got || pop);
        entry_wdata = ins_got ? {head_rdata, char_reg} : {free_head_reg, entry_char};
        priority if (ctl.load)
        begin
            entry_addr = free_head_reg;
        end
        else if (ctl.commit && ins_got)
        begin
            entry_addr = alloc_idx;
        end
        else
        begin
            entry_addr = head_rdata;
        end
    end

    lbcs_ram #(
        .WIDTH (PW),
        .DEPTH (NUM_BUCKETS)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .re    (head_re),
        .addr  (head_addr),
        .wdata (head_wdata),
        .rdata (head_rdata)
    );

    lbcs_ram #(
        .WIDTH (EW),
        .DEPTH (POOL_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (entry_we),
        .re    (entry_re),
        .addr  (entry_addr),
        .wdata (entry_wdata),
        .rdata (entry_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            func_reg   <= item_func;
            char_reg   <= item_character;
            bucket_reg <= item_letter.idx;
            letter_reg <= item_letter.valid;
        end
        if (ctl.commit)
        begin
            status_reg     <= status_new;
            bucket_out_reg <= bucket_reg;
            removed_reg    <= removed_new;
            length_out_reg <= len_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            free_head_reg <= '0;
            total_reg     <= '0;
            fresh_reg     <= '0;
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctl.commit)
            begin
                out_valid_reg <= 1'b1;
                if (ins_got)
                begin
                    len_reg[bucket_reg] <= len_new;
                    total_reg           <= total_reg + LW'(1);
                    if (free_valid)
                    begin
                        free_head_reg <= entry_next;
                    end
                    else
                    begin
                        fresh_reg <= fresh_reg + LW'(1);
                    end
                end
                else if (pop)
                begin
                    len_reg[bucket_reg] <= len_new;
                    total_reg           <= total_reg - LW'(1);
                    free_head_reg       <= head_rdata;
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.need_pop = pop;
    assign stat.out_free = !out_valid_reg || rsp.ready;

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.bucket        = bucket_out_reg;
    assign rsp.removed_char  = removed_reg;
    assign rsp.bucket_length = length_out_reg;

endmodule
`default_nettype wire

>>> design/letter_bucket_chained_stacks_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// letter_bucket_chained_stacks_top: letter bucket chained stacks
// Twenty-six case-insensitive letter buckets, each a stack chained through a
// shared entry pool with a free list.
// ----------------------------------------------------------------------------
// Each item carries an operation and a character. Insert and count query
// items, and delete items that find their bucket empty or carry no letter,
// pass through the head read state to their result item; a delete that pops
// also passes the pop state, because a pop must read the bucket head pointer
// before it can read the entry that it points to, and both sit in single-port
// memories. A new item is accepted in the cycle after the previous result is
// loaded into the output register, so no item is taken while one is in
// flight. While the output register holds a result that has not yet been
// taken, the next item is still accepted but waits before it commits, and the
// input stalls behind it. Bucket lengths are flip-flops cleared at reset; the
// pool memories need no clearing pass.
module letter_bucket_chained_stacks_top
    import lbcs_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lbcs_cmd_if.sink   cmd,
    lbcs_rsp_if.source rsp
);

    lbcs_cmd_t  ctl;
    lbcs_stat_t stat;
    logic       ctl_ready;

    lbcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (ctl_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    lbcs_datapath #(
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .item_func      (cmd.func),
        .item_character (cmd.character),
        .rsp            (rsp)
    );

    assign cmd.ready = ctl_ready;

endmodule
`default_nettype wire
